/* rtl/core/tsat_pkg.sv */
// ----------------------------------------------------------------------------
// tsat_pkg
// Shared widths, word types and stage enables for the triangle SAT depth block.
// ----------------------------------------------------------------------------
package tsat_pkg;

    localparam int COORD_W    = 16;                 // signed Q8.8 coordinate
    localparam int AXIS_W     = COORD_W + 1;        // edge normal component
    localparam int PROD_W     = AXIS_W + COORD_W;   // one axis * coord product
    localparam int PROJ_W     = PROD_W + 1;         // projection, sum of two products
    localparam int PEN_W      = PROJ_W + 1;         // interval overlap, unsigned
    localparam int DEPTH_W    = 34;
    localparam int CMP_W      = (PEN_W > DEPTH_W) ? PEN_W : DEPTH_W;
    localparam int NUM_AXES   = 6;
    localparam int NUM_STAGES = 7;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [AXIS_W-1:0]  axis_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [PROJ_W-1:0]  proj_t;
    typedef logic        [PEN_W-1:0]   pen_t;
    typedef logic        [DEPTH_W-1:0] depth_t;

    typedef struct packed {
        coord_t tri_a_x0;
        coord_t tri_a_y0;
        coord_t tri_a_x1;
        coord_t tri_a_y1;
        coord_t tri_a_x2;
        coord_t tri_a_y2;
        coord_t tri_b_x0;
        coord_t tri_b_y0;
        coord_t tri_b_x1;
        coord_t tri_b_y1;
        coord_t tri_b_x2;
        coord_t tri_b_y2;
    } tsat_in_t;

    typedef struct packed {
        depth_t pen_depth;
        logic   overlapping;
        logic   all_edges_degenerate;
    } tsat_out_t;

    // load enables of the three stages held inside each axis unit
    typedef struct packed {
        logic mul;
        logic sum;
        logic ext;
    } tsat_en_t;

endpackage

/* rtl/core/tsat_axis.sv */
// ----------------------------------------------------------------------------
// tsat_axis
// Projects both triangles onto one edge normal: multiply, sum, then min/max.
// ----------------------------------------------------------------------------
module tsat_axis
    import tsat_pkg::*;
(
    input  logic     aclk,
    input  tsat_en_t en,
    input  axis_t    ax,
    input  axis_t    ay,
    input  coord_t   px [2][3],
    input  coord_t   py [2][3],
    output proj_t    lo [2],
    output proj_t    hi [2]
);

    prod_t prod_x_reg [2][3];
    prod_t prod_y_reg [2][3];
    proj_t dot_reg    [2][3];
    proj_t lo_reg     [2];
    proj_t hi_reg     [2];

    prod_t prod_x_next [2][3];
    prod_t prod_y_next [2][3];
    proj_t dot_next    [2][3];
    proj_t lo_next     [2];
    proj_t hi_next     [2];

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 3; k++) begin
                prod_x_next[s][k] = prod_t'(ax) * prod_t'(px[s][k]);
                prod_y_next[s][k] = prod_t'(ay) * prod_t'(py[s][k]);
                dot_next[s][k]    = proj_t'(prod_x_reg[s][k]) + proj_t'(prod_y_reg[s][k]);
            end
        end
    end

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            lo_next[s] = dot_reg[s][0];
            hi_next[s] = dot_reg[s][0];
            for (int k = 1; k < 3; k++) begin
                if (dot_reg[s][k] < lo_next[s]) begin
                    lo_next[s] = dot_reg[s][k];
                end
                if (dot_reg[s][k] > hi_next[s]) begin
                    hi_next[s] = dot_reg[s][k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (en.sum) begin
            dot_reg <= dot_next;
        end
        if (en.ext) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

/* rtl/core/triangle_sat_penetration_depth.sv */
// ----------------------------------------------------------------------------
// triangle_sat_penetration_depth
// Separating axis test of two 2-D triangles giving the minimum penetration depth.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  s_        in   s_valid / s_ready  tsat_in_t  : twelve Q8.8 vertex coords
//  m_        out  m_valid / m_ready  tsat_out_t : depth, overlap, degenerate flag
//
//  Seven register stages; m_valid is the valid bit of the last of them.
//  One word per cycle sustained while m_ready holds, as the 72 multipliers are fully pipelined.
//  Reset (aresetn low at a clock edge) clears only the stage valid bits.
//  Stalls: a stage loads only when empty or when the next stage loads, so
//  bubbles close up; s_ready falls only once every stage holds a word.
// ----------------------------------------------------------------------------
module triangle_sat_penetration_depth
    import tsat_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tsat_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tsat_out_t m_data
);

    // ---- stage control -----------------------------------------------------
    // vld_reg[k] marks a word held in stage k+1; stg_en[k] loads stage k+1.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stg_en;

    always_comb begin
        stg_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stg_en[k] = !vld_reg[k] || stg_en[k+1];
        end
        vld_next[0] = s_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (stg_en[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_ready = stg_en[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    // ---- stage 1: capture vertices, form edge normals (-dy, dx) -----------
    coord_t in_x [2][3];
    coord_t in_y [2][3];

    always_comb begin
        in_x[0][0] = s_data.tri_a_x0;  in_y[0][0] = s_data.tri_a_y0;
        in_x[0][1] = s_data.tri_a_x1;  in_y[0][1] = s_data.tri_a_y1;
        in_x[0][2] = s_data.tri_a_x2;  in_y[0][2] = s_data.tri_a_y2;
        in_x[1][0] = s_data.tri_b_x0;  in_y[1][0] = s_data.tri_b_y0;
        in_x[1][1] = s_data.tri_b_x1;  in_y[1][1] = s_data.tri_b_y1;
        in_x[1][2] = s_data.tri_b_x2;  in_y[1][2] = s_data.tri_b_y2;
    end

    coord_t                crd_x_reg [2][3];
    coord_t                crd_y_reg [2][3];
    axis_t                 ax_reg    [NUM_AXES];
    axis_t                 ay_reg    [NUM_AXES];
    axis_t                 ax_next   [NUM_AXES];
    axis_t                 ay_next   [NUM_AXES];
    logic [NUM_AXES-1:0]   tst1_next;
    logic [NUM_AXES-1:0]   tst1_reg;

    // axis index is triangle*3 + edge; edge e runs from vertex e to e+1 mod 3
    always_comb begin
        for (int t = 0; t < 2; t++) begin
            for (int e = 0; e < 3; e++) begin
                ax_next[t*3+e] = axis_t'(in_y[t][e]) - axis_t'(in_y[t][(e+1)%3]);
                ay_next[t*3+e] = axis_t'(in_x[t][(e+1)%3]) - axis_t'(in_x[t][e]);
                // zero-length edge gives no axis
                tst1_next[t*3+e] = (ax_next[t*3+e] != '0) || (ay_next[t*3+e] != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            crd_x_reg <= in_x;
            crd_y_reg <= in_y;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            tst1_reg  <= tst1_next;
        end
    end

    // ---- stages 2 to 4: per-axis projection intervals ---------------------
    tsat_en_t axis_en;
    proj_t    ax_lo [NUM_AXES][2];
    proj_t    ax_hi [NUM_AXES][2];

    assign axis_en.mul = stg_en[1];
    assign axis_en.sum = stg_en[2];
    assign axis_en.ext = stg_en[3];

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
        tsat_axis u_axis (
            .aclk (aclk),
            .en   (axis_en),
            .ax   (ax_reg[i]),
            .ay   (ay_reg[i]),
            .px   (crd_x_reg),
            .py   (crd_y_reg),
            .lo   (ax_lo[i]),
            .hi   (ax_hi[i])
        );
    end

    // tested-axis flags ride alongside the axis units
    logic [NUM_AXES-1:0] tst2_reg;
    logic [NUM_AXES-1:0] tst3_reg;
    logic [NUM_AXES-1:0] tst4_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[1]) begin
            tst2_reg <= tst1_reg;
        end
        if (stg_en[2]) begin
            tst3_reg <= tst2_reg;
        end
        if (stg_en[3]) begin
            tst4_reg <= tst3_reg;
        end
    end

    // ---- stage 5: gap test and overlap per axis ---------------------------
    // Strict gap only: equal extents count as touching, overlap zero.
    pen_t                  pen5_next [NUM_AXES];
    pen_t                  pen5_reg  [NUM_AXES];
    logic [NUM_AXES-1:0]   sep5_vec;
    logic                  sep5_reg;
    logic [NUM_AXES-1:0]   tst5_reg;
    proj_t                 min_hi    [NUM_AXES];
    proj_t                 max_lo    [NUM_AXES];
    logic signed [PEN_W-1:0] ovl     [NUM_AXES];

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            sep5_vec[i] = tst4_reg[i] &&
                          ((ax_hi[i][0] < ax_lo[i][1]) || (ax_hi[i][1] < ax_lo[i][0]));
            min_hi[i]   = (ax_hi[i][0] < ax_hi[i][1]) ? ax_hi[i][0] : ax_hi[i][1];
            max_lo[i]   = (ax_lo[i][1] < ax_lo[i][0]) ? ax_lo[i][0] : ax_lo[i][1];
            ovl[i]      = PEN_W'(min_hi[i]) - PEN_W'(max_lo[i]);
            pen5_next[i] = pen_t'(ovl[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[4]) begin
            pen5_reg <= pen5_next;
            sep5_reg <= |sep5_vec;
            tst5_reg <= tst4_reg;
        end
    end

    // ---- stage 6: pairwise minimum over tested axes -----------------------
    localparam int NUM_PAIRS = NUM_AXES / 2;

    pen_t                 pen6_next [NUM_PAIRS];
    pen_t                 pen6_reg  [NUM_PAIRS];
    logic [NUM_PAIRS-1:0] tst6_next;
    logic [NUM_PAIRS-1:0] tst6_reg;
    logic                 sep6_reg;

    always_comb begin
        for (int j = 0; j < NUM_PAIRS; j++) begin
            if (tst5_reg[2*j] && (!tst5_reg[2*j+1] || pen5_reg[2*j] <= pen5_reg[2*j+1])) begin
                pen6_next[j] = pen5_reg[2*j];
            end else begin
                pen6_next[j] = pen5_reg[2*j+1];
            end
            tst6_next[j] = tst5_reg[2*j] || tst5_reg[2*j+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[5]) begin
            pen6_reg <= pen6_next;
            tst6_reg <= tst6_next;
            sep6_reg <= sep5_reg;
        end
    end

    // ---- stage 7: final minimum, saturation, output register --------------
    pen_t                best_pen;
    logic                best_tst;
    logic [CMP_W-1:0]    best_ext;
    tsat_out_t           m_data_next;
    tsat_out_t           m_data_reg;

    always_comb begin
        best_pen = pen6_reg[0];
        best_tst = tst6_reg[0];
        for (int j = 1; j < NUM_PAIRS; j++) begin
            if (tst6_reg[j] && (!best_tst || pen6_reg[j] < best_pen)) begin
                best_pen = pen6_reg[j];
            end
            best_tst = best_tst || tst6_reg[j];
        end
        best_ext = CMP_W'(best_pen);

        if (sep6_reg) begin
            m_data_next.pen_depth            = '0;
            m_data_next.overlapping          = 1'b0;
            m_data_next.all_edges_degenerate = 1'b0;
        end else if (!best_tst) begin
            // both triangles are points: no axis at all
            m_data_next.pen_depth            = DEPTH_MAX;
            m_data_next.overlapping          = 1'b1;
            m_data_next.all_edges_degenerate = 1'b1;
        end else begin
            if (best_ext > CMP_W'(DEPTH_MAX)) begin
                m_data_next.pen_depth = DEPTH_MAX;
            end else begin
                m_data_next.pen_depth = DEPTH_W'(best_ext);
            end
            m_data_next.overlapping          = 1'b1;
            m_data_next.all_edges_degenerate = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[NUM_STAGES-1]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_data = m_data_reg;

    // ---- assertions -------------------------------------------------------
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted word not held in first stage");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&vld_reg))
        else $error("input stalled while a stage is empty");

    a_sep_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_en[NUM_STAGES-1] && vld_reg[NUM_STAGES-2] && sep6_reg |=>
            !m_data.overlapping && (m_data.pen_depth == '0))
        else $error("separated pair gave nonzero depth or overlap");

    a_degen_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_en[NUM_STAGES-1] && vld_reg[NUM_STAGES-2] && !sep6_reg && !(|tst6_reg) |=>
            m_data.all_edges_degenerate && (m_data.pen_depth == DEPTH_MAX))
        else $error("degenerate pair not saturated");

endmodule

/* tb/tsat_depth_checker.sv */
// ----------------------------------------------------------------------------
// tsat_depth_checker
// Watches both channels of the triangle SAT depth block, predicts each result
// word from the accepted input word and compares it field by field.
// ----------------------------------------------------------------------------
module tsat_depth_checker
    import tsat_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  tsat_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  tsat_out_t m_data,
    output int        words_in_flight,
    output int        mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    tsat_out_t pending_depths[$];
    int        errors = 0;

    assign mismatch_count = errors;

    // Minimum overlap over the non-degenerate edge normals of both triangles.
    function automatic tsat_out_t sat_min_depth(input tsat_in_t w);
        longint    vx[2][3];
        longint    vy[2][3];
        longint    lo[2];
        longint    hi[2];
        longint    ax, ay, d, pen, best;
        bit        tested;
        int        t, e, s, k, n;
        tsat_out_t r;
        vx[0][0] = w.tri_a_x0; vy[0][0] = w.tri_a_y0;
        vx[0][1] = w.tri_a_x1; vy[0][1] = w.tri_a_y1;
        vx[0][2] = w.tri_a_x2; vy[0][2] = w.tri_a_y2;
        vx[1][0] = w.tri_b_x0; vy[1][0] = w.tri_b_y0;
        vx[1][1] = w.tri_b_x1; vy[1][1] = w.tri_b_y1;
        vx[1][2] = w.tri_b_x2; vy[1][2] = w.tri_b_y2;
        tested = 1'b0;
        best   = 0;
        for (t = 0; t < 2; t++) begin
            for (e = 0; e < 3; e++) begin
                n  = (e + 1) % 3;
                ax = vy[t][e] - vy[t][n];
                ay = vx[t][n] - vx[t][e];
                if (ax == 0 && ay == 0)
                    continue;       // zero-length edge gives no axis
                for (s = 0; s < 2; s++) begin
                    for (k = 0; k < 3; k++) begin
                        d = ax * vx[s][k] + ay * vy[s][k];
                        if (k == 0 || d < lo[s]) lo[s] = d;
                        if (k == 0 || d > hi[s]) hi[s] = d;
                    end
                end
                if (hi[0] < lo[1] || hi[1] < lo[0]) begin
                    r.pen_depth            = '0;
                    r.overlapping          = 1'b0;
                    r.all_edges_degenerate = 1'b0;
                    return r;
                end
                pen = ((hi[0] < hi[1]) ? hi[0] : hi[1]) - ((lo[1] < lo[0]) ? lo[0] : lo[1]);
                if (!tested || pen < best)
                    best = pen;
                tested = 1'b1;
            end
        end
        if (!tested) begin
            r.pen_depth            = DEPTH_MAX;
            r.overlapping          = 1'b1;
            r.all_edges_degenerate = 1'b1;
        end else begin
            r.pen_depth            = (best > longint'(DEPTH_MAX)) ? DEPTH_MAX : depth_t'(best);
            r.overlapping          = 1'b1;
            r.all_edges_degenerate = 1'b0;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        tsat_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_depths.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %0d/%0b/%0b",
                             $time, m_data.pen_depth, m_data.overlapping,
                             m_data.all_edges_degenerate);
                    errors++;
                end else begin
                    want = pending_depths.pop_front();
                    if (m_data.pen_depth !== want.pen_depth) begin
                        $display("%0t: pen_depth expected %0d, got %0d",
                                 $time, want.pen_depth, m_data.pen_depth);
                        errors++;
                    end
                    if (m_data.overlapping !== want.overlapping) begin
                        $display("%0t: overlapping expected %0b, got %0b",
                                 $time, want.overlapping, m_data.overlapping);
                        errors++;
                    end
                    if (m_data.all_edges_degenerate !== want.all_edges_degenerate) begin
                        $display("%0t: all_edges_degenerate expected %0b, got %0b",
                                 $time, want.all_edges_degenerate,
                                 m_data.all_edges_degenerate);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                pending_depths.push_back(sat_min_depth(s_data));
        end
        words_in_flight <= pending_depths.size();
    end

endmodule

/* tb/triangle_sat_penetration_depth_test.sv */
// ----------------------------------------------------------------------------
// triangle_sat_penetration_depth_test
// Drives triangle pairs into the SAT depth block: a directed set covering
// degenerate, touching, separated and extreme-coordinate pairs, then random
// pairs under three idling mixes. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module triangle_sat_penetration_depth_test
    import tsat_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 533;
    localparam int DRAIN_CYCLES = 16;   // pipeline is 7 deep, leave margin

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tsat_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tsat_out_t m_data;

    int words_in_flight;
    int mismatch_count;

    // idle odds in percent per cycle, changed between phases
    int send_idle_pct = 6;
    int recv_idle_pct = 82;

    triangle_sat_penetration_depth dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    tsat_depth_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .words_in_flight (words_in_flight),
        .mismatch_count  (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Present one triangle pair and hold it until accepted. Idle cycles go in
    // front of the word, so valid only drops between words.
    task automatic send_pair(input int ax0, ay0, ax1, ay1, ax2, ay2,
                             input int bx0, by0, bx1, by1, bx2, by2);
        tsat_in_t w;
        w.tri_a_x0 = coord_t'(ax0); w.tri_a_y0 = coord_t'(ay0);
        w.tri_a_x1 = coord_t'(ax1); w.tri_a_y1 = coord_t'(ay1);
        w.tri_a_x2 = coord_t'(ax2); w.tri_a_y2 = coord_t'(ay2);
        w.tri_b_x0 = coord_t'(bx0); w.tri_b_y0 = coord_t'(by0);
        w.tri_b_x1 = coord_t'(bx1); w.tri_b_y1 = coord_t'(by1);
        w.tri_b_x2 = coord_t'(bx2); w.tri_b_y2 = coord_t'(by2);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Random pair. Most are clustered so that overlap, separation, touching
    // and degenerate edges all turn up; the rest are full-range or extreme.
    // Cluster centres stay within +-8000 so reflected vertices still fit.
    task automatic send_random_pair();
        int a[6];
        int b[6];
        int kind, sel, r, cx, cy, bx, by;
        kind = $urandom_range(99);
        if (kind < 15) begin
            // full range, every coordinate bit toggles
            for (int i = 0; i < 6; i++) begin
                a[i] = $urandom_range(65535);
                b[i] = $urandom_range(65535);
            end
        end else if (kind < 95) begin
            r  = 1 << $urandom_range(11, 3);
            cx = int'($urandom_range(16000)) - 8000;
            cy = int'($urandom_range(16000)) - 8000;
            bx = cx + int'($urandom_range(4 * r)) - 2 * r;
            by = cy + int'($urandom_range(4 * r)) - 2 * r;
            for (int i = 0; i < 6; i++) begin
                a[i] = ((i % 2 == 0) ? cx : cy) + int'($urandom_range(2 * r)) - r;
                b[i] = ((i % 2 == 0) ? bx : by) + int'($urandom_range(2 * r)) - r;
            end
            sel = $urandom_range(3);
            if (kind >= 70 && kind < 85) begin
                b[0] = a[0];
                b[1] = a[1];
                if (sel[0]) begin
                    // shared edge, B is A reflected through the edge midpoint
                    b[2] = a[2];
                    b[3] = a[3];
                    b[4] = a[0] + a[2] - a[4];
                    b[5] = a[1] + a[3] - a[5];
                end else begin
                    // shared vertex, B is A reflected through it
                    b[2] = 2 * a[0] - a[2];
                    b[3] = 2 * a[1] - a[3];
                    b[4] = 2 * a[0] - a[4];
                    b[5] = 2 * a[1] - a[5];
                end
            end else if (kind >= 85) begin
                // degenerate edges, up to both triangles collapsed to points
                case (sel)
                    0: begin
                        a[2] = a[0]; a[3] = a[1];
                    end
                    1: begin
                        a[2] = a[0]; a[3] = a[1]; a[4] = a[0]; a[5] = a[1];
                    end
                    2: begin
                        b[2] = b[0]; b[3] = b[1]; b[4] = b[0]; b[5] = b[1];
                    end
                    default: begin
                        a[2] = a[0]; a[3] = a[1]; a[4] = a[0]; a[5] = a[1];
                        b[2] = b[0]; b[3] = b[1]; b[4] = b[0]; b[5] = b[1];
                    end
                endcase
            end
        end else begin
            // corner values only
            for (int i = 0; i < 12; i++) begin
                case ($urandom_range(3))
                    0:       sel = -32768;
                    1:       sel = 32767;
                    2:       sel = 0;
                    default: sel = -1;
                endcase
                if (i < 6) a[i] = sel;
                else       b[i - 6] = sel;
            end
        end
        send_pair(a[0], a[1], a[2], a[3], a[4], a[5],
                  b[0], b[1], b[2], b[3], b[4], b[5]);
    endtask

    initial begin
        // synchronous reset, then release
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // -- directed words --
        // both triangles collapsed to points: no axis, depth saturates
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(256, -256, 256, -256, 256, -256,
                  -32768, 32767, -32768, 32767, -32768, 32767);
        send_pair(32767, 32767, 32767, 32767, 32767, 32767,
                  32767, 32767, 32767, 32767, 32767, 32767);
        send_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                  -32768, -32768, -32768, -32768, -32768, -32768);
        // full-range triangles, largest products and depths
        send_pair(-32768, -32768, 32767, -32768, -32768, 32767,
                  -32768, -32768, 32767, -32768, -32768, 32767);
        send_pair(-32768, -32768, 32767, -32768, -32768, 32767,
                  32767, 32767, 32767, -32768, -32768, 32767);
        send_pair(-32768, 32767, 32767, -32768, 0, 0,
                  32767, 32767, -32768, -32768, 32767, -32768);
        // clearly separated
        send_pair(0, 0, 256, 0, 0, 256, 1024, 1024, 1280, 1024, 1024, 1280);
        // touching along an edge and at a single vertex: depth zero
        send_pair(0, 0, 256, 0, 0, 256, 256, 0, 0, 256, 256, 256);
        send_pair(0, 0, 256, 0, 0, 256, 256, 0, 512, 0, 512, 256);
        // B is a point, inside then outside A
        send_pair(0, 0, 512, 0, 0, 512, 64, 64, 64, 64, 64, 64);
        send_pair(0, 0, 512, 0, 0, 512, 1000, 1000, 1000, 1000, 1000, 1000);
        // one zero-length edge in A
        send_pair(0, 0, 0, 0, 256, 256, 0, 0, 256, 0, 0, 256);
        // collinear A, all edges non-zero
        send_pair(0, 0, 128, 128, 256, 256, -64, 0, 320, 0, 128, 300);
        // alternating bit patterns
        send_pair(21845, -21846, 21845, 21845, -21846, 21845,
                  -21846, 21845, -21846, -21846, 21845, -21846);
        send_pair(-21846, 21845, -21846, -21846, 21845, -21846,
                  21845, -21846, 21845, 21845, -21846, 21845);
        // small A wholly inside large B
        send_pair(-16, -16, 16, -16, 0, 16, -4096, -4096, 4096, -4096, 0, 4096);

        // hold off until the pipeline has drained completely
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_in_flight != 0)
            @(posedge aclk);

        // -- random words, three idling mixes --
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                send_idle_pct = 82;
                recv_idle_pct = 6;
            end else if (n == 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_pair();
        end

        // drain, then wait out DRAIN_CYCLES for anything stray
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_in_flight != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog: the slowest correct run is well under a tenth of this
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
